// ===== src/colmap_pkg.sv =====
// ----------------------------------------------------------------------------
// colmap_pkg
// Shared widths, codes and types of the colour-map lookup and blend block.
// ----------------------------------------------------------------------------
package colmap_pkg;

    localparam int PALETTE_COLOURS_DEF = 64;

    localparam int LUMA_W     = 8;
    localparam int COVER_W    = 8;
    localparam int INDEX_W    = 7;
    localparam int ENTRY_W    = 16;
    localparam int LEVEL_W    = 18;
    localparam int FRAC_W     = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    // request function codes
    localparam logic FUNC_PIXEL       = 1'b0;
    localparam logic FUNC_TABLE_WRITE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_INVERT_LUMA = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FILL_LEVEL  = 1'd1;

    // coverage below this masks the pixel to the fill level
    localparam logic [COVER_W-1:0] COVER_LIMIT = 8'd128;

    // one palette word: all three channels of one entry
    typedef struct packed {
        logic [ENTRY_W-1:0] red;
        logic [ENTRY_W-1:0] green;
        logic [ENTRY_W-1:0] blue;
    } colmap_rgb_t;

    // request in the read stage, handed to the blend stage
    typedef struct packed {
        logic               valid;
        logic               masked;
        logic [FRAC_W-1:0]  frac;
        logic [ENTRY_W-1:0] fill;
    } colmap_stage_t;

endpackage

// ===== src/colmap_palette_ram.sv =====
// ----------------------------------------------------------------------------
// colmap_palette_ram
// Palette memory: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module colmap_palette_ram #(
    parameter int DEPTH = colmap_pkg::PALETTE_COLOURS_DEF + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                    aclk,
    input  logic                    wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  colmap_pkg::colmap_rgb_t wr_data,
    input  logic                    rd_en,
    input  logic [AW-1:0]           rd_addr0,
    input  logic [AW-1:0]           rd_addr1,
    output colmap_pkg::colmap_rgb_t rd_data0,
    output colmap_pkg::colmap_rgb_t rd_data1
);

    colmap_pkg::colmap_rgb_t palette_mem [DEPTH];
    colmap_pkg::colmap_rgb_t rd_data0_reg;
    colmap_pkg::colmap_rgb_t rd_data1_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            palette_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data0_reg <= palette_mem[rd_addr0];
            rd_data1_reg <= palette_mem[rd_addr1];
        end
    end

    assign rd_data0 = rd_data0_reg;
    assign rd_data1 = rd_data1_reg;

endmodule

// ===== src/colmap_blend.sv =====
// ----------------------------------------------------------------------------
// colmap_blend
// Linear blend of two palette words, fill override and the result register.
// ----------------------------------------------------------------------------
module colmap_blend (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  colmap_pkg::colmap_stage_t             stage,
    input  colmap_pkg::colmap_rgb_t               lo_word,
    input  colmap_pkg::colmap_rgb_t               hi_word,
    output logic                                  take,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [colmap_pkg::LEVEL_W-1:0]        m_red_level,
    output logic [colmap_pkg::LEVEL_W-1:0]        m_green_level,
    output logic [colmap_pkg::LEVEL_W-1:0]        m_blue_level,
    output logic                                  m_masked
);

    // e0*(256-f) + e1*f, divided by 64 and rounded half up, in 1/4 entry units
    function automatic logic [colmap_pkg::LEVEL_W-1:0] blend(
        input logic [colmap_pkg::ENTRY_W-1:0] e0,
        input logic [colmap_pkg::ENTRY_W-1:0] e1,
        input logic [colmap_pkg::FRAC_W-1:0]  f
    );
        logic [24:0] sum;
        logic [24:0] rnd;
        sum = 25'(e0) * 25'(10'd256 - 10'(f)) + 25'(e1) * 25'(f);
        rnd = sum + 25'd32;
        return rnd[23:6];
    endfunction

    logic                               m_valid_reg, m_valid_next;
    logic [colmap_pkg::LEVEL_W-1:0]     red_reg, green_reg, blue_reg;
    logic                               masked_reg;
    logic [colmap_pkg::LEVEL_W-1:0]     red_next, green_next, blue_next;
    logic [colmap_pkg::LEVEL_W-1:0]     fill_lvl;

    assign take     = !m_valid_reg || m_ready;
    assign fill_lvl = {stage.fill, 2'b00};

    always_comb begin
        m_valid_next = take ? stage.valid : m_valid_reg;
        if (stage.masked) begin
            red_next   = fill_lvl;
            green_next = fill_lvl;
            blue_next  = fill_lvl;
        end else begin
            red_next   = blend(lo_word.red,   hi_word.red,   stage.frac);
            green_next = blend(lo_word.green, hi_word.green, stage.frac);
            blue_next  = blend(lo_word.blue,  hi_word.blue,  stage.frac);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && stage.valid) begin
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            masked_reg <= stage.masked;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_red_level   = red_reg;
    assign m_green_level = green_reg;
    assign m_blue_level  = blue_reg;
    assign m_masked      = masked_reg;

    // masked pixels carry one level on all channels
    a_masked_grey: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_masked |-> (m_red_level == m_green_level) &&
                                (m_green_level == m_blue_level))
        else $error("masked result with differing channels");

    // a request taken from the read stage shows up as a result
    a_stage_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        stage.valid && take |=> m_valid)
        else $error("read stage request lost");

endmodule

// ===== src/colour_map_lut_interpolate_top.sv =====
// ----------------------------------------------------------------------------
// colour_map_lut_interpolate_top
// Luminance to RGB colour map: palette lookup with linear interpolation.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  s_*       in         s_valid / s_ready    func, luma, coverage, entry_index,
//                                            red/green/blue_entry
//  m_*       out        m_valid / m_ready    red/green/blue_level, masked
//  cfg_*     in         cfg_wr_en            cfg_wr_index, cfg_wr_data
//
//  One request per cycle while s_ready is high. The edge that accepts a pixel
//  request loads the palette memory read register and the read stage; the
//  blend result register is loaded from them when it is free or being taken.
//  Table writes update the memory at acceptance, no result.
//  aresetn is synchronous, active low; it clears the control state and the
//  config registers. The palette memory has no reset and holds garbage until
//  loaded. With m_ready low the result register holds, the read stage fills,
//  and s_ready drops until the result is taken.
//
// Pipeline:
//   accept : invert, scale luma to entry/fraction, read entries x0 and x0+1
//            from memory (both ports) if unmasked, or write one entry.
//   stage 1: registered palette words + fraction/mask/fill -> blend.
//   output : result register toward m_*.
// A write followed by a read of the same entry is safe: the write lands at
// its acceptance edge, before the edge that accepts the next request.
// ----------------------------------------------------------------------------
module colour_map_lut_interpolate_top #(
    parameter int PALETTE_COLOURS = colmap_pkg::PALETTE_COLOURS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [colmap_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  logic [colmap_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    // requests
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_func,
    input  logic [colmap_pkg::LUMA_W-1:0]        s_luma,
    input  logic [colmap_pkg::COVER_W-1:0]       s_coverage,
    input  logic [colmap_pkg::INDEX_W-1:0]       s_entry_index,
    input  logic [colmap_pkg::ENTRY_W-1:0]       s_red_entry,
    input  logic [colmap_pkg::ENTRY_W-1:0]       s_green_entry,
    input  logic [colmap_pkg::ENTRY_W-1:0]       s_blue_entry,
    // results
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [colmap_pkg::LEVEL_W-1:0]       m_red_level,
    output logic [colmap_pkg::LEVEL_W-1:0]       m_green_level,
    output logic [colmap_pkg::LEVEL_W-1:0]       m_blue_level,
    output logic                                 m_masked
);

    localparam int DEPTH = PALETTE_COLOURS + 1;
    localparam int AW    = $clog2(DEPTH);

    // configuration registers
    logic                                invert_luma_reg;
    logic [colmap_pkg::ENTRY_W-1:0]      fill_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_luma_reg <= 1'b0;
            fill_level_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                colmap_pkg::REG_INVERT_LUMA: invert_luma_reg <= cfg_wr_data[0];
                colmap_pkg::REG_FILL_LEVEL:  fill_level_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // acceptance and request decode
    logic                          s_accept;
    logic                          is_pixel;
    logic                          is_masked;
    logic                          take;
    logic                          st1_valid_reg, st1_valid_next;
    logic                          st1_masked_reg;
    logic [colmap_pkg::FRAC_W-1:0] st1_frac_reg;
    logic [colmap_pkg::ENTRY_W-1:0] st1_fill_reg;
    colmap_pkg::colmap_stage_t     st1;

    assign s_ready   = !st1_valid_reg || take;
    assign s_accept  = s_valid && s_ready;
    assign is_pixel  = (s_func == colmap_pkg::FUNC_PIXEL);
    assign is_masked = (s_coverage < colmap_pkg::COVER_LIMIT);

    // luma -> entry and fraction: pos = pix * PALETTE_COLOURS, x0 = pos / 256
    logic [colmap_pkg::LUMA_W-1:0] pix;
    logic [16:0]                   pos;
    logic [AW-1:0]                 rd_addr0, rd_addr1;
    logic [colmap_pkg::FRAC_W-1:0] frac;

    assign pix      = invert_luma_reg ? ~s_luma : s_luma;
    assign pos      = 17'(pix) * 17'(PALETTE_COLOURS);
    assign rd_addr0 = AW'(pos[16:8]);
    assign rd_addr1 = AW'(pos[16:8]) + AW'(1);
    assign frac     = pos[7:0];

    // table write, ignored beyond the last entry
    logic                    wr_en;
    logic                    rd_en;
    colmap_pkg::colmap_rgb_t wr_word;

    assign wr_en   = s_accept && (s_func == colmap_pkg::FUNC_TABLE_WRITE) &&
                     (int'(s_entry_index) <= PALETTE_COLOURS);
    assign rd_en   = s_accept && is_pixel && !is_masked;
    assign wr_word = '{red: s_red_entry, green: s_green_entry, blue: s_blue_entry};

    colmap_pkg::colmap_rgb_t lo_word, hi_word;

    colmap_palette_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (AW'(s_entry_index)),
        .wr_data  (wr_word),
        .rd_en    (rd_en),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .rd_data0 (lo_word),
        .rd_data1 (hi_word)
    );

    // read stage control
    always_comb begin
        if (s_accept && is_pixel) begin
            st1_valid_next = 1'b1;
        end else if (take) begin
            st1_valid_next = 1'b0;
        end else begin
            st1_valid_next = st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && is_pixel) begin
            st1_masked_reg <= is_masked;
            st1_frac_reg   <= frac;
            st1_fill_reg   <= fill_level_reg;
        end
    end

    assign st1 = '{valid:  st1_valid_reg,
                   masked: st1_masked_reg,
                   frac:   st1_frac_reg,
                   fill:   st1_fill_reg};

    colmap_blend u_blend (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .stage         (st1),
        .lo_word       (lo_word),
        .hi_word       (hi_word),
        .take          (take),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_level   (m_red_level),
        .m_green_level (m_green_level),
        .m_blue_level  (m_blue_level),
        .m_masked      (m_masked)
    );

    // table writes never occupy the read stage
    a_write_no_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !is_pixel |=> !st1_valid_reg)
        else $error("table write entered the read stage");

    // every accepted pixel sits in the read stage after the accepting edge
    a_pixel_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && is_pixel |=> st1_valid_reg)
        else $error("pixel request dropped at the read stage");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule
